// ===== rtl/tshd_pkg.sv =====
// Shared types, result codes and helpers for the time-slice hit decoder.
package tshd_pkg;

	localparam logic [31:0] MAGIC_WORD = 32'hc0da0100;

	localparam logic [2:0] KIND_CHARGE   = 3'd0;
	localparam logic [2:0] KIND_WIRE     = 3'd1;
	localparam logic [2:0] KIND_BAD_MAG  = 3'd2;
	localparam logic [2:0] KIND_PORT_MIS = 3'd3;
	localparam logic [2:0] KIND_UNK_MOD  = 3'd4;
	localparam logic [2:0] KIND_TBL_OVF  = 3'd5;

	localparam logic [3:0] MOD_DIGITIZER = 4'd0;
	localparam logic [3:0] MOD_WIRE      = 4'd1;

	typedef enum logic [6:0] {
		PH_HEADER    = 7'b0000001,
		PH_ROC       = 7'b0000010,
		PH_INFO      = 7'b0000100,
		PH_BANK_LEN  = 7'b0001000,
		PH_BANK_HEAD = 7'b0010000,
		PH_DATA      = 7'b0100000,
		PH_SKIP      = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] frame_no;
		logic [63:0] frame_stamp;
		logic [15:0] roc_id;
		logic [15:0] slot;
		logic [8:0]  channel;
		logic [12:0] charge;
		logic [15:0] time_ns;
		logic        last;
	} hit_t;

	typedef struct packed {
		logic        active;
		logic [8:0]  channel;
		logic [15:0] time_ns;
		logic        last;
	} wire_hit_t;

	function automatic logic [31:0] rev_bytes(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// ===== rtl/tshd_if.sv =====
// Valid/ready channel interfaces for input words and decoded hits.
interface tshd_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface tshd_hit_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] frame_no;
	logic [63:0] frame_stamp;
	logic [15:0] roc_id;
	logic [15:0] slot;
	logic [8:0]  channel;
	logic [12:0] charge;
	logic [15:0] time_ns;
	logic        last;
	modport source (output valid, output kind, output frame_no, output frame_stamp,
		output roc_id, output slot, output channel, output charge, output time_ns,
		output last, input ready);
	modport sink (input valid, input kind, input frame_no, input frame_stamp,
		input roc_id, input slot, input channel, input charge, input time_ns,
		input last, output ready);
endinterface

// ===== rtl/tshd_expand.sv =====
// Wire pattern walker: emits one hit per set bit, lowest bit first.
module tshd_expand (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [47:0]       load_pat,
	input  logic [2:0]        load_grp,
	input  logic [15:0]       load_time,
	input  logic              take,
	output tshd_pkg::wire_hit_t hit
);
	import tshd_pkg::*;

	logic [47:0] pat_q;
	logic [2:0]  grp_q;
	logic [15:0] time_q;
	logic [5:0]  idx;
	logic [47:0] rest;

	always_comb begin
		idx = 6'd0;
		for (int b = 47; b >= 0; b--) begin
			if (pat_q[b]) idx = 6'(b);
		end
	end

	assign rest = pat_q & (pat_q - 48'd1);

	assign hit.active  = (pat_q != 48'd0);
	assign hit.channel = 9'(idx) + {grp_q, 5'd0} + {1'b0, grp_q, 4'd0};
	assign hit.time_ns = time_q;
	assign hit.last    = (rest == 48'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
		end else if (load) begin
			pat_q <= load_pat;
		end else if (take && hit.active) begin
			pat_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q  <= load_grp;
			time_q <= load_time;
		end
	end

endmodule

// ===== rtl/time_slice_hit_decoder.sv =====
// Time-slice hit decoder: parses block/bank words and emits charge hits, wire hits and error results.
// A charge hit or error result is registered on the output in the cycle after its word is taken.
// Throughput: one word per cycle while the output is free; a wire pair stalls input
// while the walker sends one hit per set bit, one per free cycle, via the output register.
// Reset (arst_n low) clears all parse state and the halt flag; the port table
// memory is not cleared, only entries written in the current block are read.
module time_slice_hit_decoder #(
	parameter int MAX_PORT_ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	tshd_word_if.sink  words,
	tshd_hit_if.source hits
);
	import tshd_pkg::*;

	localparam int CW   = $clog2(MAX_PORT_ENTRIES + 1);
	localparam int ROWS = (MAX_PORT_ENTRIES + 1) / 2;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

	// parse state
	phase_t      phase_q, phase_n;
	logic [3:0]  hdr_q, hdr_n;
	logic [31:0] blk_left_q, blk_left_n;
	logic        swap_q, swap_n;
	logic [31:0] frame_q, frame_n;
	logic [31:0] stamp_lo_q, stamp_lo_n;
	logic [31:0] stamp_hi_q, stamp_hi_n;
	logic [15:0] roc_q, roc_n;
	logic [15:0] info_left_q, info_left_n;
	logic        pad_q, pad_n;
	logic [CW-1:0] port_cnt_q, port_cnt_n;
	logic [CW-1:0] bank_idx_q, bank_idx_n;
	logic [31:0] bank_left_q, bank_left_n;
	logic [3:0]  module_q, module_n;
	logic [15:0] slot_q, slot_n;
	logic [31:0] held_q, held_n;
	logic        pend_q, pend_n;
	logic        halt_q, halt_n;

	// port table: two 16-bit entries per row, low half holds the even entry
	logic [31:0] ptab [ROWS];
	logic [31:0] ptab_rd_q;
	logic        tab_we;
	logic [31:0] tab_wdata;
	logic [15:0] entry;

	// result register
	logic        out_v_q;
	hit_t        out_q;
	logic        out_free;

	// per-word effects
	logic        acc;
	logic        emit_charge;
	logic        emit_err;
	logic [2:0]  err_kind;
	logic        wire_load;
	logic [47:0] wire_pat;
	logic [31:0] w;
	logic [31:0] len;
	logic [16:0] entries;
	logic [CW-1:0] next_idx;
	wire_hit_t   wh;

	assign out_free    = !out_v_q || hits.ready;
	assign words.ready = !wh.active && out_free;
	assign acc         = words.valid && words.ready;
	assign w           = swap_q ? rev_bytes(words.word) : words.word;
	assign entry       = bank_idx_q[0] ? ptab_rd_q[31:16] : ptab_rd_q[15:0];
	assign wire_pat    = {w[18:0], held_q[28:0]};

	always_comb begin
		phase_n     = phase_q;
		hdr_n       = hdr_q;
		blk_left_n  = blk_left_q;
		swap_n      = swap_q;
		frame_n     = frame_q;
		stamp_lo_n  = stamp_lo_q;
		stamp_hi_n  = stamp_hi_q;
		roc_n       = roc_q;
		info_left_n = info_left_q;
		pad_n       = pad_q;
		port_cnt_n  = port_cnt_q;
		bank_idx_n  = bank_idx_q;
		bank_left_n = bank_left_q;
		module_n    = module_q;
		slot_n      = slot_q;
		held_n      = held_q;
		pend_n      = pend_q;
		halt_n      = halt_q;
		emit_charge = 1'b0;
		emit_err    = 1'b0;
		err_kind    = KIND_BAD_MAG;
		wire_load   = 1'b0;
		tab_we      = 1'b0;
		tab_wdata   = w;
		len         = '0;
		entries     = '0;
		next_idx    = bank_idx_q + CW'(1);

		if (acc && !halt_q) begin
			if (phase_q == PH_HEADER) begin
				if (hdr_q == 4'd0) blk_left_n = words.word;
				if (hdr_q < 4'd7) begin
					hdr_n = hdr_q + 4'd1;
				end else begin
					hdr_n = 4'd0;
					if (words.word == MAGIC_WORD) begin
						swap_n = 1'b0;
					end else if (rev_bytes(words.word) == MAGIC_WORD) begin
						swap_n = 1'b1;
					end else begin
						emit_err = 1'b1;
						err_kind = KIND_BAD_MAG;
					end
					if (!emit_err) begin
						len        = swap_n ? rev_bytes(blk_left_q) : blk_left_q;
						blk_left_n = (len > 32'd6) ? len - 32'd6 : 32'd0;
						if (blk_left_n != 32'd0) phase_n = PH_ROC;
					end
				end
			end else begin
				unique case (phase_q)
					PH_ROC: begin
						if (hdr_q == 4'd1) roc_n = w[31:16];
						if (hdr_q == 4'd5) frame_n = w;
						if (hdr_q == 4'd6) stamp_lo_n = w;
						if (hdr_q == 4'd7) stamp_hi_n = w;
						if (hdr_q < 4'd8) begin
							hdr_n = hdr_q + 4'd1;
						end else begin
							hdr_n       = 4'd0;
							info_left_n = w[15:0];
							pad_n       = w[23];
							entries     = {w[15:0], 1'b0} -
								17'((w[23] && w[15:0] != 16'd0) ? 1 : 0);
							if (entries > 17'(MAX_PORT_ENTRIES)) begin
								emit_err = 1'b1;
								err_kind = KIND_TBL_OVF;
							end else begin
								port_cnt_n = '0;
								bank_idx_n = '0;
								phase_n    = (w[15:0] != 16'd0) ? PH_INFO : PH_SKIP;
							end
						end
					end
					PH_INFO: begin
						tab_we      = 1'b1;
						port_cnt_n  = port_cnt_q +
							((info_left_q == 16'd1 && pad_q) ? CW'(1) : CW'(2));
						info_left_n = info_left_q - 16'd1;
						if (info_left_n == 16'd0) begin
							bank_idx_n = '0;
							phase_n    = (port_cnt_n == '0) ? PH_SKIP : PH_BANK_LEN;
						end
					end
					PH_BANK_LEN: begin
						bank_left_n = (w == 32'd0) ? 32'd0 : w - 32'd1;
						phase_n     = PH_BANK_HEAD;
					end
					PH_BANK_HEAD: begin
						if ({3'd0, entry[4:0]} != w[23:16]) begin
							emit_err = 1'b1;
							err_kind = KIND_PORT_MIS;
						end else begin
							slot_n   = w[31:16];
							module_n = entry[11:8];
							pend_n   = 1'b0;
							if (bank_left_q == 32'd0) begin
								bank_idx_n = next_idx;
								phase_n    = (next_idx >= port_cnt_q) ? PH_SKIP : PH_BANK_LEN;
							end else begin
								phase_n = PH_DATA;
							end
						end
					end
					PH_DATA: begin
						if (module_q == MOD_DIGITIZER) begin
							emit_charge = 1'b1;
						end else if (module_q == MOD_WIRE) begin
							if (!pend_q) begin
								held_n = w;
								pend_n = 1'b1;
							end else begin
								wire_load = 1'b1;
								pend_n    = 1'b0;
							end
						end else begin
							emit_err = 1'b1;
							err_kind = KIND_UNK_MOD;
						end
						if (!emit_err) begin
							bank_left_n = bank_left_q - 32'd1;
							if (bank_left_n == 32'd0) begin
								pend_n     = 1'b0;
								bank_idx_n = next_idx;
								phase_n    = (next_idx >= port_cnt_q) ? PH_SKIP : PH_BANK_LEN;
							end
						end
					end
					default: ;
				endcase
				// count the payload word; drop back to the block header at its end
				if (!emit_err) begin
					blk_left_n = blk_left_q - 32'd1;
					if (blk_left_n == 32'd0) begin
						phase_n = PH_HEADER;
						hdr_n   = 4'd0;
						pend_n  = 1'b0;
					end
				end
			end
			if (emit_err) halt_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_q       <= '0;
			blk_left_q  <= '0;
			swap_q      <= 1'b0;
			frame_q     <= '0;
			stamp_lo_q  <= '0;
			stamp_hi_q  <= '0;
			roc_q       <= '0;
			info_left_q <= '0;
			pad_q       <= 1'b0;
			port_cnt_q  <= '0;
			bank_idx_q  <= '0;
			bank_left_q <= '0;
			module_q    <= '0;
			slot_q      <= '0;
			held_q      <= '0;
			pend_q      <= 1'b0;
			halt_q      <= 1'b0;
		end else begin
			phase_q     <= phase_n;
			hdr_q       <= hdr_n;
			blk_left_q  <= blk_left_n;
			swap_q      <= swap_n;
			frame_q     <= frame_n;
			stamp_lo_q  <= stamp_lo_n;
			stamp_hi_q  <= stamp_hi_n;
			roc_q       <= roc_n;
			info_left_q <= info_left_n;
			pad_q       <= pad_n;
			port_cnt_q  <= port_cnt_n;
			bank_idx_q  <= bank_idx_n;
			bank_left_q <= bank_left_n;
			module_q    <= module_n;
			slot_q      <= slot_n;
			held_q      <= held_n;
			pend_q      <= pend_n;
			halt_q      <= halt_n;
		end
	end

	// Port table memory. Entries are written in pairs at an even count, so one row
	// write per info word suffices. The read tracks the current bank entry every
	// cycle; the length word always sits between the last write and the head check.
	always_ff @(posedge clk) begin
		if (tab_we) ptab[port_cnt_q[RAW:1]] <= tab_wdata;
		ptab_rd_q <= ptab[bank_idx_q[RAW:1]];
	end

	tshd_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (wire_load),
		.load_pat  (wire_pat),
		.load_grp  (held_q[31:29]),
		.load_time ({w[29:19], 5'd0}),
		.take      (out_free),
		.hit       (wh)
	);

	// Output register: the walker has priority; input is held off while it runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (wh.active && out_free) begin
			out_v_q <= 1'b1;
		end else if (emit_charge || emit_err) begin
			out_v_q <= 1'b1;
		end else if (hits.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wh.active && out_free) begin
			out_q.kind        <= KIND_WIRE;
			out_q.frame_no    <= frame_q;
			out_q.frame_stamp <= {stamp_hi_q, stamp_lo_q};
			out_q.roc_id      <= roc_q;
			out_q.slot        <= slot_q;
			out_q.channel     <= wh.channel;
			out_q.charge      <= '0;
			out_q.time_ns     <= wh.time_ns;
			out_q.last        <= wh.last;
		end else if (emit_err) begin
			// zero every field but the kind and last flag
			out_q <= '{kind: err_kind, last: 1'b1, default: '0};
		end else if (emit_charge) begin
			out_q.kind        <= KIND_CHARGE;
			out_q.frame_no    <= frame_q;
			out_q.frame_stamp <= {stamp_hi_q, stamp_lo_q};
			out_q.roc_id      <= roc_q;
			out_q.slot        <= slot_q;
			out_q.channel     <= {5'd0, w[16:13]};
			out_q.charge      <= w[12:0];
			out_q.time_ns     <= {w[30:17], 2'b00};
			out_q.last        <= 1'b1;
		end
	end

	assign hits.valid       = out_v_q;
	assign hits.kind        = out_q.kind;
	assign hits.frame_no    = out_q.frame_no;
	assign hits.frame_stamp = out_q.frame_stamp;
	assign hits.roc_id      = out_q.roc_id;
	assign hits.slot        = out_q.slot;
	assign hits.channel     = out_q.channel;
	assign hits.charge      = out_q.charge;
	assign hits.time_ns     = out_q.time_ns;
	assign hits.last        = out_q.last;

	// no word may enter while the wire walker still drains a pattern
	a_walk_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		wh.active |-> !words.ready)
		else $error("word taken during wire expansion");

	// an error halts the block until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	// the port table never holds more entries than it has room for
	a_tab_bound: assert property (@(posedge clk) disable iff (!arst_n)
		port_cnt_q <= CW'(MAX_PORT_ENTRIES))
		else $error("port table count beyond capacity");

endmodule
